// ----- hdl/fir_filter_mac_unit_defines.svh -----
// Assertion macros shared by the filter RTL.
// No dependencies; included by modules that carry assertions.
`ifndef FIR_FILTER_MAC_UNIT_DEFINES_SVH
`define FIR_FILTER_MAC_UNIT_DEFINES_SVH

// same-cycle implication
`define FMAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FMAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fmac_pkg.sv -----
// Shared widths, constants and types for the FIR filter MAC unit.
// No dependencies.
package fmac_pkg;

    localparam int DATA_W    = 16;
    localparam int TAP_IDX_W = 11;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 48;
    localparam int SHIFT_W   = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd15;

    localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic clear;
        logic vld;
        logic last;
    } t_mac_ctrl;

endpackage

// ----- hdl/fmac_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module fmac_ram #(
    parameter int DEPTH = 2048,
    parameter int W     = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fmac_mac.sv -----
// Multiply-accumulate datapath with output shift and saturation.
// Depends on fmac_pkg and fir_filter_mac_unit_defines.svh.
`include "fir_filter_mac_unit_defines.svh"

module fmac_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fmac_pkg::t_mac_ctrl                 i_ctrl,
    input  logic signed [fmac_pkg::DATA_W-1:0]  i_coef,
    input  logic signed [fmac_pkg::DATA_W-1:0]  i_sample,
    input  logic [fmac_pkg::SHIFT_W-1:0]        i_shift,
    output logic                                o_done,
    output logic signed [fmac_pkg::DATA_W-1:0]  o_filtered,
    output logic                                o_saturated
);

    logic signed [fmac_pkg::PROD_W-1:0] r_prod;
    logic                               r_pvld;
    logic                               r_plast;
    logic signed [fmac_pkg::ACC_W-1:0]  r_acc;
    logic                               r_done;
    logic signed [fmac_pkg::ACC_W-1:0]  w_shifted;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
        if (!i_rst_n) begin
            r_pvld  <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_pvld  <= i_ctrl.vld;
            r_plast <= i_ctrl.last;
            if (i_ctrl.clear) begin
                r_acc  <= '0;
                r_done <= 1'b0;
            end else if (r_pvld) begin
                r_acc <= r_acc + fmac_pkg::ACC_W'(r_prod);
                if (r_plast) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_shifted = r_acc >>> i_shift;

    always_comb begin
        o_saturated = 1'b0;
        o_filtered  = w_shifted[fmac_pkg::DATA_W-1:0];
        if (w_shifted > fmac_pkg::ACC_W'(fmac_pkg::OUT_MAX)) begin
            o_filtered  = fmac_pkg::OUT_MAX;
            o_saturated = 1'b1;
        end else if (w_shifted < fmac_pkg::ACC_W'(fmac_pkg::OUT_MIN)) begin
            o_filtered  = fmac_pkg::OUT_MIN;
            o_saturated = 1'b1;
        end
    end

    assign o_done = r_done;

    `FMAC_ASSERT_NXT(a_clear_acc, i_clk, i_rst_n, i_ctrl.clear, (r_acc == '0) && !r_done, "accumulator not cleared")
    `FMAC_ASSERT_IMP(a_done_after_last, i_clk, i_rst_n, $rose(r_done), $past(r_plast) && !r_pvld, "done without last product")

endmodule

// ----- hdl/fir_filter_mac_unit.sv -----
// Top level of the FIR filter MAC unit: sequencer, memories and MAC datapath.
// Depends on fmac_pkg, fmac_ram, fmac_mac and fir_filter_mac_unit_defines.svh.
//
//  channel | direction | signals                                  | transfer
//  --------+-----------+------------------------------------------+-------------------------
//  in      | to unit   | i_command, i_tap_index, i_value          | i_valid && o_ready
//  out     | from unit | o_filtered, o_saturated                  | o_valid && i_ready
//  cfg     | to unit   | i_cfg_data (result shift)                | i_cfg_valid && o_cfg_ready
//
// A sample is filtered by one shared MAC that walks all taps, one coefficient and one delayed
// sample read per cycle from the two memories.
// After reset both memories are cleared; o_ready stays low meanwhile.
// Reset is synchronous, active low. A waiting result does not block new input;
// a finished sum waits for the output register to free up.
`include "fir_filter_mac_unit_defines.svh"

module fir_filter_mac_unit #(
    parameter int TAPS = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic [fmac_pkg::TAP_IDX_W-1:0]      i_tap_index,
    input  logic signed [fmac_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fmac_pkg::DATA_W-1:0]  o_filtered,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fmac_pkg::SHIFT_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    t_state                              r_state;
    logic [AW-1:0]                       r_k;
    logic [AW-1:0]                       r_rp;
    logic [AW-1:0]                       r_wp;
    logic                                r_rvld;
    logic                                r_rlast;
    logic [fmac_pkg::SHIFT_W-1:0]        r_shift;
    logic                                r_out_vld;
    logic signed [fmac_pkg::DATA_W-1:0]  r_filtered;
    logic                                r_sat;

    logic                                w_in_xfer;
    logic                                w_load;
    logic                                w_sample;
    logic                                w_out_free;
    logic                                w_coef_we;
    logic [AW-1:0]                       w_coef_waddr;
    logic [fmac_pkg::DATA_W-1:0]         w_coef_wdata;
    logic                                w_smp_we;
    logic [AW-1:0]                       w_smp_waddr;
    logic [fmac_pkg::DATA_W-1:0]         w_smp_wdata;
    logic [fmac_pkg::DATA_W-1:0]         w_coef_rd;
    logic [fmac_pkg::DATA_W-1:0]         w_smp_rd;
    fmac_pkg::t_mac_ctrl                 w_mac_ctrl;
    logic                                w_mac_done;
    logic signed [fmac_pkg::DATA_W-1:0]  w_mac_filtered;
    logic                                w_mac_sat;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_valid && o_ready;
    assign w_load      = w_in_xfer && (i_command == fmac_pkg::CMD_LOAD)
                         && (int'(i_tap_index) < TAPS);
    assign w_sample    = w_in_xfer && (i_command == fmac_pkg::CMD_SAMPLE);
    assign w_out_free  = !r_out_vld || i_ready;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_coef_we    = 1'b1;
            w_coef_waddr = r_k;
            w_coef_wdata = '0;
            w_smp_we     = 1'b1;
            w_smp_waddr  = r_k;
            w_smp_wdata  = '0;
        end else begin
            w_coef_we    = w_load;
            w_coef_waddr = AW'(i_tap_index);
            w_coef_wdata = i_value;
            w_smp_we     = w_sample;
            w_smp_waddr  = r_wp;
            w_smp_wdata  = i_value;
        end
    end

    fmac_ram #(.DEPTH(TAPS), .W(fmac_pkg::DATA_W)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (w_coef_wdata),
        .i_raddr (r_k),
        .o_rdata (w_coef_rd)
    );

    fmac_ram #(.DEPTH(TAPS), .W(fmac_pkg::DATA_W)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_we),
        .i_waddr (w_smp_waddr),
        .i_wdata (w_smp_wdata),
        .i_raddr (r_rp),
        .o_rdata (w_smp_rd)
    );

    assign w_mac_ctrl.clear = w_sample;
    assign w_mac_ctrl.vld   = r_rvld;
    assign w_mac_ctrl.last  = r_rlast;

    fmac_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_mac_ctrl),
        .i_coef      (w_coef_rd),
        .i_sample    (w_smp_rd),
        .i_shift     (r_shift),
        .o_done      (w_mac_done),
        .o_filtered  (w_mac_filtered),
        .o_saturated (w_mac_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_k       <= '0;
            r_rp      <= '0;
            r_wp      <= '0;
            r_rvld    <= 1'b0;
            r_rlast   <= 1'b0;
            r_shift   <= fmac_pkg::SHIFT_RST;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_shift <= i_cfg_data;
            end
            if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end
            r_rvld  <= 1'b0;
            r_rlast <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == LAST_IDX) begin
                        r_k     <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_sample) begin
                        r_k     <= '0;
                        r_rp    <= r_wp;
                        r_wp    <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rvld  <= 1'b1;
                    r_rlast <= (r_k == LAST_IDX);
                    r_k     <= r_k + 1'b1;
                    r_rp    <= (r_rp == '0) ? LAST_IDX : r_rp - 1'b1;
                    if (r_k == LAST_IDX) begin
                        r_k     <= '0;
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_mac_done && w_out_free) begin
                        r_out_vld  <= 1'b1;
                        r_filtered <= w_mac_filtered;
                        r_sat      <= w_mac_sat;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_vld;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_sat;

    `FMAC_ASSERT_IMP(a_rd_in_pass, i_clk, i_rst_n, r_rvld, $past(r_state == ST_RUN), "tap read outside a pass")
    `FMAC_ASSERT_NXT(a_result_out, i_clk, i_rst_n, (r_state == ST_FINISH) && w_mac_done && w_out_free, o_valid && (r_state == ST_IDLE), "finished sum not delivered")

endmodule

// ----- bench/fir_filter_mac_unit_test.sv -----
// Self-checking bench for fir_filter_mac_unit: coefficient loads, filtered samples, result shift.
// Depends on fmac_pkg and fir_filter_mac_unit; keeps its own copy of the taps and delay line.
`timescale 1ns / 1ps

module fir_filter_mac_unit_test;

    localparam int TAPS           = 2048;
    localparam int TAP_AW         = $clog2(TAPS);
    localparam int WATCHDOG_LIMIT = 12 * TAPS;
    localparam int HOLD_CYCLES    = 4 * TAPS;
    localparam int DRAIN_GAP      = 16;
    localparam int CHUNK          = 30;

    typedef struct {
        logic signed [fmac_pkg::DATA_W-1:0] filtered;
        logic                               saturated;
    } t_fir_out;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_valid;
    logic                                  o_ready;
    logic                                  i_command;
    logic [fmac_pkg::TAP_IDX_W-1:0]        i_tap_index;
    logic signed [fmac_pkg::DATA_W-1:0]    i_value;
    logic                                  o_valid;
    logic                                  i_ready;
    logic signed [fmac_pkg::DATA_W-1:0]    o_filtered;
    logic                                  o_saturated;
    logic                                  i_cfg_valid;
    logic                                  o_cfg_ready;
    logic [fmac_pkg::SHIFT_W-1:0]          i_cfg_data;

    logic signed [fmac_pkg::DATA_W-1:0]    coef_model [TAPS];
    logic signed [fmac_pkg::DATA_W-1:0]    delay_model [TAPS];
    logic [fmac_pkg::SHIFT_W-1:0]          shift_model;
    t_fir_out                              pending_outputs [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit stall_request   = 1'b0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    fir_filter_mac_unit #(
        .TAPS(TAPS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_tap_index (i_tap_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_filtered  (o_filtered),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output side: random back-pressure, or a long hold-off on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_outputs
        t_fir_out exp_out;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("output transfer with no sample pending: filtered %0d", o_filtered);
                mismatch_count++;
            end else begin
                exp_out = pending_outputs.pop_front();
                if (o_filtered !== exp_out.filtered) begin
                    $error("filtered: expected %0d, got %0d", exp_out.filtered, o_filtered);
                    mismatch_count++;
                end
                if (o_saturated !== exp_out.saturated) begin
                    $error("saturated: expected %0b, got %0b", exp_out.saturated, o_saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one input transfer; valid is left high so back-to-back items need no gap
    task automatic send_item(input logic cmd, input logic [fmac_pkg::TAP_IDX_W-1:0] tap,
                             input logic signed [fmac_pkg::DATA_W-1:0] val);
        longint   acc;
        longint   shifted;
        t_fir_out out_item;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_tap_index <= tap;
        i_value     <= val;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);

        if (cmd == fmac_pkg::CMD_LOAD) begin
            if (int'(tap) < TAPS)
                coef_model[tap] = val;
        end else begin
            for (int k = TAPS - 1; k > 0; k--)
                delay_model[TAP_AW'(k)] = delay_model[TAP_AW'(k - 1)];
            delay_model[0] = val;
            acc = 0;
            for (int k = 0; k < TAPS; k++)
                acc += longint'(coef_model[TAP_AW'(k)]) * longint'(delay_model[TAP_AW'(k)]);
            shifted = acc >>> shift_model;
            out_item.saturated = 1'b1;
            if (shifted > longint'(fmac_pkg::OUT_MAX))
                out_item.filtered = fmac_pkg::OUT_MAX;
            else if (shifted < longint'(fmac_pkg::OUT_MIN))
                out_item.filtered = fmac_pkg::OUT_MIN;
            else begin
                out_item.filtered  = shifted[fmac_pkg::DATA_W-1:0];
                out_item.saturated = 1'b0;
            end
            pending_outputs.push_back(out_item);
        end
    endtask

    task automatic send_random();
        logic                               cmd;
        logic [fmac_pkg::TAP_IDX_W-1:0]     tap;
        logic signed [fmac_pkg::DATA_W-1:0] val;
        cmd = 1'($urandom_range(0, 1));
        // most loads land where the delay line actually holds samples
        if ($urandom_range(0, 3) == 0)
            tap = fmac_pkg::TAP_IDX_W'($urandom_range(0, (1 << fmac_pkg::TAP_IDX_W) - 1));
        else
            tap = fmac_pkg::TAP_IDX_W'($urandom_range(0, 47));
        case ($urandom_range(0, 9))
            0:       val = fmac_pkg::OUT_MAX;
            1:       val = fmac_pkg::OUT_MIN;
            default: val = fmac_pkg::DATA_W'($urandom());
        endcase
        send_item(cmd, tap, val);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [fmac_pkg::SHIFT_W-1:0] shift);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= shift;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shift_model = shift;
    endtask

    // runs on the reset value of the shift
    task automatic test_reset_shift();
        send_item(fmac_pkg::CMD_LOAD, '0, fmac_pkg::OUT_MAX);
        send_item(fmac_pkg::CMD_LOAD, fmac_pkg::TAP_IDX_W'(1), fmac_pkg::OUT_MIN);
        send_item(fmac_pkg::CMD_LOAD, fmac_pkg::TAP_IDX_W'(TAPS - 1), fmac_pkg::OUT_MIN);
        send_item(fmac_pkg::CMD_SAMPLE, '0, fmac_pkg::OUT_MAX);
        send_item(fmac_pkg::CMD_SAMPLE, '1, fmac_pkg::OUT_MIN);
        send_item(fmac_pkg::CMD_SAMPLE, 11'h2AA, 16'sd0);
    endtask

    task automatic test_shift_extremes();
        pause_until_drained();
        write_shift(5'd0);
        send_item(fmac_pkg::CMD_SAMPLE, '0, 16'sd1);
        send_item(fmac_pkg::CMD_SAMPLE, 11'h555, -16'sd1);
        send_item(fmac_pkg::CMD_LOAD, fmac_pkg::TAP_IDX_W'(1), 16'sd0);
        send_item(fmac_pkg::CMD_SAMPLE, '0, 16'sd0);
        pause_until_drained();
        write_shift(5'd31);
        send_item(fmac_pkg::CMD_SAMPLE, '0, fmac_pkg::OUT_MIN);
        send_item(fmac_pkg::CMD_SAMPLE, '1, fmac_pkg::OUT_MAX);
    endtask

    // receiver stalls long enough for the unit to back up into its input
    task automatic test_hold_off();
        int saved_pct;
        pause_until_drained();
        write_shift(fmac_pkg::SHIFT_RST);
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        stall_request = 1'b1;
        repeat (6) send_item(fmac_pkg::CMD_SAMPLE, fmac_pkg::TAP_IDX_W'($urandom()),
                             fmac_pkg::DATA_W'($urandom()));
        send_idle_pct = saved_pct;
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (3) begin
            pause_until_drained();
            if ($urandom_range(0, 3) == 0)
                write_shift(fmac_pkg::SHIFT_W'($urandom_range(0, 31)));
            else
                write_shift(fmac_pkg::SHIFT_W'($urandom_range(12, 24)));
            repeat (CHUNK) send_random();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = fmac_pkg::CMD_LOAD;
        i_tap_index = '0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = fmac_pkg::SHIFT_RST;
        shift_model = fmac_pkg::SHIFT_RST;
        for (int k = 0; k < TAPS; k++) begin
            coef_model[TAP_AW'(k)]  = '0;
            delay_model[TAP_AW'(k)] = '0;
        end
        send_idle_pct = 38;
        recv_idle_pct = 71;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_shift();
        test_shift_extremes();
        test_hold_off();
        test_random_traffic(38, 71);
        test_random_traffic(71, 38);
        test_random_traffic(0, 0);

        pause_until_drained();
        repeat (TAPS + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/fmac_pkg.sv
hdl/fmac_ram.sv
hdl/fmac_mac.sv
hdl/fir_filter_mac_unit.sv
bench/fir_filter_mac_unit_test.sv
